// ----- hdl/doa_pkg.sv -----
package doa_pkg;

   localparam int DEPTH_W  = 8;
   localparam int Q_W      = 16;
   localparam int WEIGHT_W = 9;
   localparam int CONF_W   = 4;
   localparam int TURN_W   = 6;
   localparam int CSR_IDX_W = 3;

   typedef logic [DEPTH_W-1:0]         depth_type;
   typedef logic [Q_W-1:0]             q88_type;
   typedef logic [WEIGHT_W-1:0]        weight_type;
   typedef logic [CONF_W-1:0]          conf_type;
   typedef logic signed [TURN_W-1:0]   turn_type;
   typedef logic [1:0]                 motion_type;
   typedef logic [CSR_IDX_W-1:0]       csr_idx_type;

   // full weight: new sample only
   localparam weight_type WEIGHT_ONE = 9'd256;

   // register map
   localparam csr_idx_type CSR_SAFE_THR  = 3'd0;
   localparam csr_idx_type CSR_CAUT_THR  = 3'd1;
   localparam csr_idx_type CSR_EXIT_THR  = 3'd2;
   localparam csr_idx_type CSR_WEIGHT    = 3'd3;
   localparam csr_idx_type CSR_CONF_LIM  = 3'd4;

   localparam depth_type  SAFE_THR_RST  = 8'd122;
   localparam depth_type  CAUT_THR_RST  = 8'd135;
   localparam depth_type  EXIT_THR_RST  = 8'd145;
   localparam weight_type WEIGHT_RST    = 9'd179;
   localparam conf_type   CONF_LIM_RST  = 4'd3;
   localparam q88_type    SMOOTH_RST    = 16'd34560;

   // motion codes
   localparam motion_type MOTION_FULL   = 2'd0;
   localparam motion_type MOTION_HALF   = 2'd1;
   localparam motion_type MOTION_HOLD   = 2'd2;
   localparam motion_type MOTION_RETURN = 2'd3;

   // heading steps, half degrees
   localparam turn_type TURN_SMALL = 6'sd10;
   localparam turn_type TURN_BIG   = 6'sd30;
   localparam turn_type TURN_HALF  = 6'sd5;

   localparam conf_type CONF_EXIT_LOAD = 4'd2;
   localparam logic [7:0] OOB_MIN_TICKS = 8'd3;

endpackage

// ----- hdl/doa_filter.sv -----
module doa_filter (
   input  doa_pkg::weight_type weight,
   input  doa_pkg::depth_type  straight,
   input  doa_pkg::q88_type    smoothed,
   output doa_pkg::q88_type    smoothed_next
);
   import doa_pkg::*;

   // s*w + m*(256-w) rewritten as 256*m + w*(s-m): one multiplier
   localparam int DIFF_W = Q_W + 2;
   localparam int ACC_W  = DIFF_W + WEIGHT_W + 1;

   weight_type                w_clip;
   logic signed [DIFF_W-1:0]  diff;
   logic signed [ACC_W-1:0]   prod;
   logic signed [ACC_W-1:0]   acc;
   logic [ACC_W-9:0]          acc_shr;

   assign w_clip = (weight > WEIGHT_ONE) ? WEIGHT_ONE : weight;
   assign diff   = $signed({2'b00, straight, 8'h00}) - $signed({2'b00, smoothed});
   assign prod   = $signed({1'b0, w_clip}) * diff;
   assign acc    = $signed({{(ACC_W-Q_W-8){1'b0}}, smoothed, 8'h00}) + prod
                   + $signed(ACC_W'(128));
   assign acc_shr = acc[ACC_W-1:8];

   // saturate the Q8.8 result
   assign smoothed_next = (acc_shr[ACC_W-9:Q_W] != '0) ? {Q_W{1'b1}} : acc_shr[Q_W-1:0];

endmodule

// ----- hdl/depth_obstacle_avoid_fsm.sv -----
// channel | direction | handshake              | word
// req     | in        | req_valid / req_ready  | flight flag, depth-valid flag, seven depths,
//         |           |                        | zone flag, tie bit
// rsp     | out       | rsp_valid / rsp_ready  | state, motion, turn step, flags, filter, confidence
// csr     | in        | csr_valid / csr_ready  | register index, write data (always ready)
//
// One word per cycle sustained while rsp is not stalled. A word lands in the input register and is
// decided by the single pass through the filter multiplier and the state logic once its result has
// room; the result is then held in the result register that drives rsp. A word with in_flight low is
// dropped and gives no result. Reset (synchronous) starts in search heading with a filtered depth
// of 135.0 and the register defaults. While rsp is stalled the result holds and one more word with
// a result waits in the input register; then req_ready drops.
module depth_obstacle_avoid_fsm (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_in_flight,
   input  logic                   req_depths_valid,
   input  doa_pkg::depth_type     req_block0,
   input  doa_pkg::depth_type     req_block1,
   input  doa_pkg::depth_type     req_block2,
   input  doa_pkg::depth_type     req_block3,
   input  doa_pkg::depth_type     req_block4,
   input  doa_pkg::depth_type     req_block5,
   input  doa_pkg::depth_type     req_block6,
   input  logic                   req_inside_zone,
   input  logic                   req_tie_bit,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_mode_state,
   output doa_pkg::motion_type    rsp_motion_mode,
   output doa_pkg::turn_type      rsp_turn_step,
   output logic                   rsp_follow_path,
   output logic                   rsp_rejoin_event,
   output logic                   rsp_emergency_event,
   output doa_pkg::q88_type       rsp_filtered_depth,
   output doa_pkg::conf_type      rsp_confidence,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  doa_pkg::csr_idx_type   csr_index,
   input  doa_pkg::weight_type    csr_wdata
);
   import doa_pkg::*;

   typedef enum logic [2:0] {
      ST_SAFE     = 3'd0,
      ST_CAUTION  = 3'd1,
      ST_OBSTACLE = 3'd2,
      ST_SEARCH   = 3'd3,
      ST_OOB      = 3'd4
   } mode_type;

   // configuration
   depth_type  safe_thr_ff, caut_thr_ff, exit_thr_ff;
   weight_type weight_ff;
   conf_type   conf_lim_ff;

   // input register
   logic       in_vld_ff;
   logic       in_flight_ff, in_dvalid_ff, in_inside_ff, in_tie_ff;
   depth_type  blk_ff [7];

   // controller state
   mode_type   mode_ff, mode_in;
   depth_type  left_ff, straight_ff, right_ff;
   depth_type  left_in, straight_in, right_in;
   q88_type    smooth_ff, smooth_in;
   conf_type   trust_ff, trust_in;
   turn_type   turn_ff, turn_in;
   logic [7:0] bounds_ff, bounds_in;
   logic       path_ff, path_in;

   // result register
   logic       rsp_vld_ff;
   mode_type   rsp_mode_ff;
   motion_type rsp_motion_ff, motion_in;
   turn_type   rsp_step_ff, step_in;
   logic       rsp_path_ff, rsp_rejoin_ff, rsp_emerg_ff;
   logic       rejoin_in;
   q88_type    rsp_smooth_ff;
   conf_type   rsp_trust_ff;

   logic       fire, update;
   logic       emerg;
   mode_type   mode_eff;
   turn_type   escalate, caution_turn;
   logic [CONF_W:0] trust_up;
   conf_type   trust_upc, trust_dn, trust_dnc, trust_calc;
   logic       ge_caut, ge_exit, ge_safe;
   logic [7:0] bounds_inc;

   // advance the input word when its result has room, or when it yields nothing
   assign fire      = in_vld_ff && (!in_flight_ff || !rsp_vld_ff || rsp_ready);
   assign update    = fire && in_flight_ff;
   assign req_ready = !in_vld_ff || fire;
   assign csr_ready = 1'b1;

   // sector minima; keep the old ones on stale data
   assign left_in     = in_dvalid_ff ? ((blk_ff[0] < blk_ff[1]) ? blk_ff[0] : blk_ff[1])
                                     : left_ff;
   assign right_in    = in_dvalid_ff ? ((blk_ff[5] < blk_ff[6]) ? blk_ff[5] : blk_ff[6])
                                     : right_ff;
   always_comb begin
      depth_type m;
      m = (blk_ff[2] < blk_ff[3]) ? blk_ff[2] : blk_ff[3];
      m = (m < blk_ff[4]) ? m : blk_ff[4];
      straight_in = in_dvalid_ff ? m : straight_ff;
   end

   doa_filter u_filter (
      .weight        (weight_ff),
      .straight      (straight_in),
      .smoothed      (smooth_ff),
      .smoothed_next (smooth_in)
   );

   // thresholds compare against the integer part of the Q8.8 filter
   assign ge_caut = smooth_in[15:8] >= caut_thr_ff;
   assign ge_exit = smooth_in[15:8] >= exit_thr_ff;
   assign ge_safe = smooth_in[15:8] >= safe_thr_ff;

   // confidence: up one when clear, down two otherwise, clamp to the limit
   assign trust_up   = {1'b0, trust_ff} + (CONF_W+1)'(1);
   assign trust_upc  = (trust_up > {1'b0, conf_lim_ff}) ? conf_lim_ff : trust_up[CONF_W-1:0];
   assign trust_dn   = (trust_ff < CONF_W'(2)) ? '0 : trust_ff - CONF_W'(2);
   assign trust_dnc  = (trust_dn > conf_lim_ff) ? conf_lim_ff : trust_dn;
   assign trust_calc = ge_caut ? trust_upc : trust_dnc;

   assign escalate     = (left_in > right_in) ? -TURN_BIG : TURN_BIG;
   assign caution_turn = (left_in > right_in) ? -TURN_SMALL :
                         (right_in > left_in) ?  TURN_SMALL :
                         (in_tie_ff ? -TURN_SMALL : TURN_SMALL);

   // raw straight depth overrides safe straight into obstacle
   assign emerg    = (mode_ff == ST_SAFE) && (straight_in < safe_thr_ff);
   assign mode_eff = emerg ? ST_OBSTACLE : mode_ff;
   assign bounds_inc = bounds_ff + 8'd1;

   always_comb begin
      mode_in   = mode_eff;
      turn_in   = emerg ? escalate : turn_ff;
      trust_in  = emerg ? '0 : trust_calc;
      path_in   = emerg ? 1'b0 : path_ff;
      bounds_in = bounds_ff;
      motion_in = MOTION_HOLD;
      step_in   = '0;
      rejoin_in = 1'b0;
      unique case (mode_eff)
         ST_SAFE: begin
            motion_in = MOTION_FULL;
            if (!in_inside_ff) begin
               mode_in = ST_OOB;
               path_in = 1'b0;
            end else if (!ge_caut) begin
               mode_in = ST_CAUTION;
               path_in = 1'b0;
            end else begin
               path_in = 1'b1;
            end
         end
         ST_CAUTION: begin
            motion_in = MOTION_HALF;
            step_in   = (caution_turn < 0) ? -TURN_HALF : TURN_HALF;
            turn_in   = caution_turn;
            if (!ge_safe) begin
               turn_in  = escalate;
               trust_in = '0;
               mode_in  = ST_OBSTACLE;
            end else if (ge_exit && trust_calc >= CONF_EXIT_LOAD) begin
               mode_in = ST_SAFE;
            end
         end
         ST_OBSTACLE: begin
            step_in = turn_in;
            if (ge_safe && trust_in >= CONF_W'(1)) begin
               mode_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            step_in = turn_ff;
            if (ge_caut && trust_calc >= CONF_EXIT_LOAD) begin
               mode_in   = ST_SAFE;
               rejoin_in = 1'b1;
            end
         end
         ST_OOB: begin
            motion_in = MOTION_RETURN;
            bounds_in = bounds_inc;
            if (bounds_inc >= OOB_MIN_TICKS && in_inside_ff) begin
               bounds_in = '0;
               trust_in  = CONF_EXIT_LOAD;
               mode_in   = ST_SEARCH;
            end
         end
         default: begin
            mode_in = mode_eff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         safe_thr_ff <= SAFE_THR_RST;
         caut_thr_ff <= CAUT_THR_RST;
         exit_thr_ff <= EXIT_THR_RST;
         weight_ff   <= WEIGHT_RST;
         conf_lim_ff <= CONF_LIM_RST;
         in_vld_ff   <= 1'b0;
         rsp_vld_ff  <= 1'b0;
         mode_ff     <= ST_SEARCH;
         left_ff     <= '0;
         straight_ff <= '0;
         right_ff    <= '0;
         smooth_ff   <= SMOOTH_RST;
         trust_ff    <= '0;
         turn_ff     <= TURN_SMALL;
         bounds_ff   <= '0;
         path_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               CSR_SAFE_THR: safe_thr_ff <= csr_wdata[DEPTH_W-1:0];
               CSR_CAUT_THR: caut_thr_ff <= csr_wdata[DEPTH_W-1:0];
               CSR_EXIT_THR: exit_thr_ff <= csr_wdata[DEPTH_W-1:0];
               CSR_WEIGHT:   weight_ff   <= csr_wdata;
               CSR_CONF_LIM: conf_lim_ff <= csr_wdata[CONF_W-1:0];
               default: ;
            endcase
         end

         // capture a new word into the input register
         if (req_valid && req_ready) begin
            in_vld_ff    <= 1'b1;
            in_flight_ff <= req_in_flight;
            in_dvalid_ff <= req_depths_valid;
            in_inside_ff <= req_inside_zone;
            in_tie_ff    <= req_tie_bit;
            blk_ff[0]    <= req_block0;
            blk_ff[1]    <= req_block1;
            blk_ff[2]    <= req_block2;
            blk_ff[3]    <= req_block3;
            blk_ff[4]    <= req_block4;
            blk_ff[5]    <= req_block5;
            blk_ff[6]    <= req_block6;
         end else if (fire) begin
            in_vld_ff <= 1'b0;
         end

         // commit state and load the result together
         if (update) begin
            mode_ff       <= mode_in;
            left_ff       <= left_in;
            straight_ff   <= straight_in;
            right_ff      <= right_in;
            smooth_ff     <= smooth_in;
            trust_ff      <= trust_in;
            turn_ff       <= turn_in;
            bounds_ff     <= bounds_in;
            path_ff       <= path_in;
            rsp_vld_ff    <= 1'b1;
            rsp_mode_ff   <= mode_in;
            rsp_motion_ff <= motion_in;
            rsp_step_ff   <= step_in;
            rsp_path_ff   <= path_in;
            rsp_rejoin_ff <= rejoin_in;
            rsp_emerg_ff  <= emerg;
            rsp_smooth_ff <= smooth_in;
            rsp_trust_ff  <= trust_in;
         end else if (rsp_ready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_vld_ff;
   assign rsp_mode_state      = rsp_mode_ff;
   assign rsp_motion_mode     = rsp_motion_ff;
   assign rsp_turn_step       = rsp_step_ff;
   assign rsp_follow_path     = rsp_path_ff;
   assign rsp_rejoin_event    = rsp_rejoin_ff;
   assign rsp_emergency_event = rsp_emerg_ff;
   assign rsp_filtered_depth  = rsp_smooth_ff;
   assign rsp_confidence      = rsp_trust_ff;

`ifndef SYNTHESIS
   // an emergency always lands in obstacle
   a_emerg_obstacle: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_emerg_ff |-> rsp_mode_ff == ST_OBSTACLE)
      else $error("emergency word not in obstacle state");

   // rejoin only on entry to safe
   a_rejoin_safe: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_rejoin_ff |-> rsp_mode_ff == ST_SAFE && !rsp_emerg_ff)
      else $error("rejoin word not in safe state");

   // heading steps come only from the fixed set
   a_step_set: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_step_ff == 6'sd0 || rsp_step_ff == TURN_HALF ||
                      rsp_step_ff == -TURN_HALF || rsp_step_ff == TURN_SMALL ||
                      rsp_step_ff == -TURN_SMALL || rsp_step_ff == TURN_BIG ||
                      rsp_step_ff == -TURN_BIG))
      else $error("turn step outside the allowed set");

   // a word with a result keeps waiting while the result register is stalled
   a_hold_pending: assert property (@(posedge clock) disable iff (reset)
      in_vld_ff && in_flight_ff && rsp_vld_ff && !rsp_ready |=> in_vld_ff && rsp_vld_ff)
      else $error("pending word lost under stall");
`endif

endmodule
